// ===== rtl/core/ppmp_pkg.sv =====
// ppmp_pkg: shared types, character codes and constants of the ASCII PPM parser.
// No dependencies; used by every module under rtl/core.
package ppmp_pkg;

    // Default sizing handed to the top-level parameters
    localparam int VALUE_BITS_DEF = 16;
    localparam int MAX_DIGITS_DEF = 5;

    // Result payload field width and digit counter width
    localparam int OUT_W    = 16;
    localparam int DCOUNT_W = 3;
    localparam logic [DCOUNT_W-1:0] DCOUNT_MAX = 3'd7;

    // Character codes
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_NINE = 8'd57;

    // Result kind codes
    localparam logic RK_HEADER = 1'b0;
    localparam logic RK_PIXEL  = 1'b1;

    // One input word
    typedef struct packed {
        logic [7:0] char_byte;
        logic       final_byte;
    } in_word_t;

    // One result word
    typedef struct packed {
        logic             result_kind;
        logic [OUT_W-1:0] col;
        logic [OUT_W-1:0] row;
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
        logic [OUT_W-1:0] img_width;
        logic [OUT_W-1:0] img_height;
        logic [OUT_W-1:0] max_value;
        logic             last_pixel;
    } result_t;

    // Power of ten, evaluated at elaboration for digit-length thresholds
    function automatic logic [63:0] pow10(input int k);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < k; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

endpackage

// ===== rtl/core/ppmp_in_reg.sv =====
// ppmp_in_reg: input register stage that captures one byte word per handshake.
// Depends on ppmp_pkg for the input word type.
module ppmp_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ppmp_pkg::in_word_t s_word,
    input  logic               take,
    output logic               word_valid,
    output ppmp_pkg::in_word_t word
);

    logic               valid_reg;
    ppmp_pkg::in_word_t word_reg;

    // Accept when empty or when the held word is consumed this cycle
    assign s_ready    = !valid_reg || take;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    // Hold the captured word until the parser takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_word;
        end
    end

endmodule

// ===== rtl/core/ppmp_parse.sv =====
// ppmp_parse: parser state and the single-pass next-state and result logic.
// Depends on ppmp_pkg for types, character codes and result kinds.
module ppmp_parse #(
    parameter int VALUE_BITS = ppmp_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = ppmp_pkg::MAX_DIGITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               word_valid,
    input  ppmp_pkg::in_word_t word,
    input  logic               out_ready,
    output logic               take,
    output logic               res_valid,
    output ppmp_pkg::result_t  res
);

    localparam int MD_W  = $clog2(MAX_DIGITS + 1);
    localparam int CMP_W = (MD_W > ppmp_pkg::DCOUNT_W) ? MD_W : ppmp_pkg::DCOUNT_W;
    localparam logic [VALUE_BITS+3:0] SAT_WIDE = {4'b0, {VALUE_BITS{1'b1}}};

    typedef enum logic [2:0] {
        PH_SIG,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXVAL,
        PH_PIXELS,
        PH_DONE
    } phase_t;

    phase_t                          phase_reg,   phase_next;
    logic                            comment_reg, comment_next;
    logic [VALUE_BITS-1:0]           accum_reg,   accum_next;
    logic [ppmp_pkg::DCOUNT_W-1:0]   dcount_reg,  dcount_next;
    logic [MD_W-1:0]                 maxdig_reg,  maxdig_next;
    logic [VALUE_BITS-1:0]           width_reg,   width_next;
    logic [VALUE_BITS-1:0]           height_reg,  height_next;
    logic [1:0]                      comp_reg,    comp_next;
    logic [VALUE_BITS-1:0]           red_reg,     red_next;
    logic [VALUE_BITS-1:0]           green_reg,   green_next;
    logic [VALUE_BITS-1:0]           col_reg,     col_next;
    logic [VALUE_BITS-1:0]           row_reg,     row_next;

    logic                  step;
    logic                  is_digit;
    logic                  finish;
    logic [VALUE_BITS+3:0] prod;
    logic [VALUE_BITS-1:0] num;
    logic [MD_W-1:0]       ndig;
    logic [VALUE_BITS:0]   col_inc;
    logic [VALUE_BITS:0]   row_inc;

    // Zero-extend or truncate a stored value onto a 16-bit result field
    function automatic logic [ppmp_pkg::OUT_W-1:0] to_out(input logic [VALUE_BITS-1:0] x);
        logic [VALUE_BITS+ppmp_pkg::OUT_W-1:0] t;
        t = {{ppmp_pkg::OUT_W{1'b0}}, x};
        return t[ppmp_pkg::OUT_W-1:0];
    endfunction

    // Consume the held word only when the result register can take a result
    assign step     = word_valid && out_ready;
    assign take     = step;
    assign is_digit = (word.char_byte >= ppmp_pkg::CH_ZERO) &&
                      (word.char_byte <= ppmp_pkg::CH_NINE);

    // Saturating decimal accumulate: acc * 10 + digit
    assign prod = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1) +
                  {{VALUE_BITS{1'b0}}, word.char_byte[3:0]};

    // Decimal length of the finished number, capped at MAX_DIGITS
    always_comb begin
        ndig = MD_W'(1);
        for (int k = 1; k < MAX_DIGITS; k++) begin
            if ({{(64-VALUE_BITS){1'b0}}, num} >= ppmp_pkg::pow10(k)) begin
                ndig = MD_W'(k + 1);
            end
        end
    end

    assign col_inc = {1'b0, col_reg} + {{VALUE_BITS{1'b0}}, 1'b1};
    assign row_inc = {1'b0, row_reg} + {{VALUE_BITS{1'b0}}, 1'b1};

    // Next state and result for the held word
    always_comb begin
        phase_next   = phase_reg;
        comment_next = comment_reg;
        accum_next   = accum_reg;
        dcount_next  = dcount_reg;
        maxdig_next  = maxdig_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        comp_next    = comp_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        finish       = 1'b0;
        res_valid    = 1'b0;
        res          = '0;

        // Scan the byte
        if (phase_reg == PH_SIG) begin
            if (word.char_byte == ppmp_pkg::CH_LF) begin
                phase_next = PH_WIDTH;
            end
        end else if (phase_reg != PH_DONE) begin
            if (comment_reg) begin
                if (word.char_byte == ppmp_pkg::CH_LF) begin
                    comment_next = 1'b0;
                end
            end else if (is_digit) begin
                accum_next = (prod > SAT_WIDE) ? {VALUE_BITS{1'b1}} : prod[VALUE_BITS-1:0];
                if (dcount_reg < ppmp_pkg::DCOUNT_MAX) begin
                    dcount_next = dcount_reg + {{(ppmp_pkg::DCOUNT_W-1){1'b0}}, 1'b1};
                end
                if ((phase_reg == PH_PIXELS) &&
                    (CMP_W'(dcount_next) >= CMP_W'(maxdig_reg))) begin
                    finish = 1'b1;
                end
            end else begin
                if (word.char_byte == ppmp_pkg::CH_HASH) begin
                    comment_next = 1'b1;
                end
                if (dcount_reg != '0) begin
                    finish = 1'b1;
                end
            end
        end

        // End of file closes any pending number
        if (word.final_byte && (dcount_next != '0) &&
            (phase_reg != PH_SIG) && (phase_reg != PH_DONE)) begin
            finish = 1'b1;
        end

        num = accum_next;

        // Close the number
        if (finish) begin
            accum_next  = '0;
            dcount_next = '0;
            unique case (phase_reg)
                PH_WIDTH: begin
                    width_next = num;
                    phase_next = PH_HEIGHT;
                end
                PH_HEIGHT: begin
                    height_next = num;
                    phase_next  = PH_MAXVAL;
                end
                PH_MAXVAL: begin
                    maxdig_next    = ndig;
                    comp_next      = 2'd0;
                    col_next       = '0;
                    row_next       = '0;
                    phase_next     = ((width_reg == '0) || (height_reg == '0)) ?
                                     PH_DONE : PH_PIXELS;
                    res_valid      = 1'b1;
                    res.result_kind = ppmp_pkg::RK_HEADER;
                    res.img_width  = to_out(width_reg);
                    res.img_height = to_out(height_reg);
                    res.max_value  = to_out(num);
                end
                PH_PIXELS: begin
                    if (comp_reg == 2'd1) begin
                        green_next = num;
                        comp_next  = 2'd2;
                    end else if (comp_reg != 2'd2) begin
                        red_next  = num;
                        comp_next = 2'd1;
                    end else begin
                        comp_next       = 2'd0;
                        res_valid       = 1'b1;
                        res.result_kind = ppmp_pkg::RK_PIXEL;
                        res.col         = to_out(col_reg);
                        res.row         = to_out(row_reg);
                        res.red         = to_out(red_reg);
                        res.green       = to_out(green_reg);
                        res.blue        = to_out(num);
                        col_next        = col_inc[VALUE_BITS-1:0];
                        // Wrap the column and advance the row
                        if (col_inc >= {1'b0, width_reg}) begin
                            col_next = '0;
                            row_next = row_inc[VALUE_BITS-1:0];
                            if (row_inc >= {1'b0, height_reg}) begin
                                res.last_pixel = 1'b1;
                                phase_next     = PH_DONE;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // Re-arm for the next file after its final byte
        if (word.final_byte) begin
            phase_next   = PH_SIG;
            comment_next = 1'b0;
            accum_next   = '0;
            dcount_next  = '0;
            maxdig_next  = MD_W'(1);
            width_next   = '0;
            height_next  = '0;
            comp_next    = 2'd0;
            red_next     = '0;
            green_next   = '0;
            col_next     = '0;
            row_next     = '0;
        end

        // No word, no result
        if (!step) begin
            res_valid = 1'b0;
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SIG;
            comment_reg <= 1'b0;
            accum_reg   <= '0;
            dcount_reg  <= '0;
            maxdig_reg  <= MD_W'(1);
            width_reg   <= '0;
            height_reg  <= '0;
            comp_reg    <= 2'd0;
            red_reg     <= '0;
            green_reg   <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            comment_reg <= comment_next;
            accum_reg   <= accum_next;
            dcount_reg  <= dcount_next;
            maxdig_reg  <= maxdig_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            comp_reg    <= comp_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    // A result is produced only when the result register has room
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_ready)
        else $error("result produced while result register is full");

    // Nothing is produced once the image is complete
    a_done_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (phase_reg == PH_DONE)) |-> !res_valid)
        else $error("result produced after the last pixel");

    // A header result comes only out of the maximum-value field
    a_header_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res.result_kind == ppmp_pkg::RK_HEADER)) |-> (phase_reg == PH_MAXVAL))
        else $error("header result outside the maximum-value field");

    // The last pixel leaves the parser in its done phase
    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.last_pixel && !word.final_byte) |=> (phase_reg == PH_DONE))
        else $error("last pixel did not end the image");

endmodule

// ===== rtl/core/ppmp_out_reg.sv =====
// ppmp_out_reg: result register that drives the result channel.
// Depends on ppmp_pkg for the result word type.
module ppmp_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  ppmp_pkg::result_t res,
    output logic              out_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output ppmp_pkg::result_t m_word
);

    logic              valid_reg;
    ppmp_pkg::result_t word_reg;

    // Room when empty or when the held word leaves this cycle
    assign out_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_word    = word_reg;

    // Hold the result until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && out_ready) begin
            word_reg <= res;
        end
    end

endmodule

// ===== rtl/core/ascii_ppm_pixel_parser.sv =====
// ascii_ppm_pixel_parser: top level of the byte-serial ASCII PPM (P3) parser.
// Depends on ppmp_pkg, ppmp_in_reg, ppmp_parse and ppmp_out_reg.
//
// Usage:
//   Input channel (s_): one text byte per word, with s_final_byte marking the
//   last byte of a file. The final byte closes any pending number and then
//   re-arms the parser for a new signature line.
//   Result channel (m_): one header word (m_result_kind = 0) after the maximum
//   value, then one pixel word (m_result_kind = 1) per three components, with
//   column, row and m_last_pixel on the final pixel of the image.
//   Path: an accepted byte is loaded into the input register; the parser's
//   result for it is loaded into the result register, which drives m_.
//   Throughput: one byte per cycle while the result register has room; the
//   parser updates all of its state in one pass from the input register.
//   Reset: synchronous, active low; both registers empty, parser waits for the
//   signature line.
//   Stall: while the result register is full and m_ready is low, the byte in
//   the input register waits there and s_ready stays low once it is full.
module ascii_ppm_pixel_parser #(
    parameter int VALUE_BITS = ppmp_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = ppmp_pkg::MAX_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [15:0] m_col,
    output logic [15:0] m_row,
    output logic [15:0] m_red,
    output logic [15:0] m_green,
    output logic [15:0] m_blue,
    output logic [15:0] m_img_width,
    output logic [15:0] m_img_height,
    output logic [15:0] m_max_value,
    output logic        m_last_pixel
);

    ppmp_pkg::in_word_t s_word;
    ppmp_pkg::in_word_t word;
    ppmp_pkg::result_t  res;
    ppmp_pkg::result_t  m_word;
    logic               word_valid;
    logic               take;
    logic               res_valid;
    logic               out_ready;

    assign s_word.char_byte  = s_char_byte;
    assign s_word.final_byte = s_final_byte;

    ppmp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    ppmp_parse #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .word_valid (word_valid),
        .word       (word),
        .out_ready  (out_ready),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    ppmp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    // Unpack the result word onto its ports
    assign m_result_kind = m_word.result_kind;
    assign m_col         = m_word.col;
    assign m_row         = m_word.row;
    assign m_red         = m_word.red;
    assign m_green       = m_word.green;
    assign m_blue        = m_word.blue;
    assign m_img_width   = m_word.img_width;
    assign m_img_height  = m_word.img_height;
    assign m_max_value   = m_word.max_value;
    assign m_last_pixel  = m_word.last_pixel;

endmodule
